/* hdl/clcd_pkg.sv */
// ---------------------------------------------------------------------------
// clcd_pkg: shared types, constants and position tables
// Holds the register set, request and result bundles and the flat list of
// timed positions that every LCD sequence walks through.
// ---------------------------------------------------------------------------
package clcd_pkg;

  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 16;
  localparam int REG_IDX_W = 3;

  // register indexes double as the length selectors of a position
  typedef enum logic [3:0] {
    SEL_ENABLE_LOW  = 4'd0,
    SEL_ENABLE_HIGH = 4'd1,
    SEL_SETTLE      = 4'd2,
    SEL_BYTE_GAP    = 4'd3,
    SEL_CLEAR_EXTRA = 4'd4,
    SEL_POWERUP     = 4'd5,
    SEL_INIT_LONG   = 4'd6,
    SEL_INIT_SHORT  = 4'd7,
    SEL_END         = 4'd8
  } sel_t;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_CMD    = 3'd1,
    OP_DATA   = 3'd2,
    OP_CURSOR = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    NIB_HOLD  = 2'd0,
    NIB_CONST = 2'd1,
    NIB_HI    = 2'd2,
    NIB_LO    = 2'd3
  } nib_src_t;

  localparam logic [NUM_REGS-1:0][REG_W-1:0] REG_RESET = {
    16'd1000, 16'd5000, 16'd50000, 16'd5000, 16'd2000, 16'd300, 16'd10, 16'd10
  };

  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [3:0] NIB_WAKE         = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

  // flat position list: init walk, then the single byte walk
  localparam int NUM_POS    = 55;
  localparam int POS_W      = 6;
  localparam int P_POWERUP  = 0;
  localparam int P_N2       = 1;
  localparam int P_S3       = 4;
  localparam int P_N4       = 5;
  localparam int P_S5       = 8;
  localparam int P_N6       = 9;
  localparam int P_S7       = 12;
  localparam int P_N8       = 13;
  localparam int P_B9       = 16;
  localparam int P_B10      = 23;
  localparam int P_B11      = 30;
  localparam int P_B12      = 37;
  localparam int P_GAP13    = 44;
  localparam int P_INIT_END = 45;
  localparam int P_BYTE     = 46;
  localparam int P_CLEAR    = 53;
  localparam int P_BYTE_END = 54;

  typedef struct packed {
    sel_t       sel;
    nib_src_t   nib_src;
    logic [3:0] nib_val;
    logic       rs_clear;
  } pos_info_t;

  typedef struct packed {
    logic       request_valid;
    logic [2:0] operation;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] col;
  } req_t;

  typedef struct packed {
    logic       rs_pin;
    logic       enable_pin;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic       request_dropped;
  } res_t;

  typedef struct packed {
    logic [NUM_REGS-1:0][REG_W-1:0] len;
    logic [NUM_REGS-1:0]            zero;
  } cfg_t;

  function automatic pos_info_t pos_info(input logic [POS_W-1:0] pos);
    pos_info_t info;
    info.sel      = SEL_END;
    info.nib_src  = NIB_LO;
    info.nib_val  = 4'h0;
    info.rs_clear = 1'b0;
    case (pos) inside
      P_POWERUP: info.sel = SEL_POWERUP;
      P_N2, P_N4, P_N6, P_N8, P_B9, P_B9+3, P_B10, P_B10+3,
      P_B11, P_B11+3, P_B12, P_B12+3, P_BYTE, P_BYTE+3:
        info.sel = SEL_ENABLE_LOW;
      P_N2+1, P_N4+1, P_N6+1, P_N8+1, P_B9+1, P_B9+4, P_B10+1, P_B10+4,
      P_B11+1, P_B11+4, P_B12+1, P_B12+4, P_BYTE+1, P_BYTE+4:
        info.sel = SEL_ENABLE_HIGH;
      P_N2+2, P_N4+2, P_N6+2, P_N8+2, P_B9+2, P_B9+5, P_B10+2, P_B10+5,
      P_B11+2, P_B11+5, P_B12+2, P_B12+5, P_BYTE+2, P_BYTE+5:
        info.sel = SEL_SETTLE;
      P_S3: info.sel = SEL_INIT_LONG;
      P_S5, P_S7: info.sel = SEL_INIT_SHORT;
      P_B9+6, P_B10+6, P_B11+6, P_B12+6, P_GAP13, P_BYTE+6:
        info.sel = SEL_BYTE_GAP;
      P_CLEAR: info.sel = SEL_CLEAR_EXTRA;
      default: info.sel = SEL_END;
    endcase
    case (pos) inside
      P_POWERUP: info.nib_src = NIB_HOLD;
      [P_N2:P_S7]: begin
        info.nib_src = NIB_CONST;
        info.nib_val = NIB_WAKE;
      end
      [P_N8:P_N8+2]: begin
        info.nib_src = NIB_CONST;
        info.nib_val = NIB_FOUR_BIT;
      end
      [P_B9:P_B9+2]: begin
        info.nib_src = NIB_CONST;
        info.nib_val = CMD_FUNCTION_SET[7:4];
      end
      [P_B9+3:P_B9+6]: begin
        info.nib_src = NIB_CONST;
        info.nib_val = CMD_FUNCTION_SET[3:0];
      end
      [P_B10:P_B10+2]: begin
        info.nib_src = NIB_CONST;
        info.nib_val = CMD_DISPLAY_ON[7:4];
      end
      [P_B10+3:P_B10+6]: begin
        info.nib_src = NIB_CONST;
        info.nib_val = CMD_DISPLAY_ON[3:0];
      end
      [P_B11:P_B11+2]: begin
        info.nib_src = NIB_CONST;
        info.nib_val = CMD_ENTRY_MODE[7:4];
      end
      [P_B11+3:P_B11+6]: begin
        info.nib_src = NIB_CONST;
        info.nib_val = CMD_ENTRY_MODE[3:0];
      end
      [P_B12:P_B12+2]: begin
        info.nib_src = NIB_CONST;
        info.nib_val = CMD_CLEAR[7:4];
      end
      [P_B12+3:P_INIT_END]: begin
        info.nib_src = NIB_CONST;
        info.nib_val = CMD_CLEAR[3:0];
      end
      [P_BYTE:P_BYTE+2]: info.nib_src = NIB_HI;
      default: info.nib_src = NIB_LO;
    endcase
    info.rs_clear = (pos inside {[P_N2:P_INIT_END]});
    return info;
  endfunction

  function automatic logic [3:0] nib_level(input pos_info_t info, input logic [7:0] cur_byte,
                                           input logic [3:0] held);
    logic [3:0] nib;
    case (info.nib_src)
      NIB_HOLD:  nib = held;
      NIB_CONST: nib = info.nib_val;
      NIB_HI:    nib = cur_byte[7:4];
      NIB_LO:    nib = cur_byte[3:0];
      default:   nib = held;
    endcase
    return nib;
  endfunction

endpackage

/* hdl/clcd_cfg_regs.sv */
// ---------------------------------------------------------------------------
// clcd_cfg_regs: timing register file
// Eight 16-bit tick lengths with a zero flag kept beside each one, so the
// sequencer can skip empty phases without a compare on the full value.
// ---------------------------------------------------------------------------
module clcd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [clcd_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [clcd_pkg::REG_W-1:0]     cfg_data,
  output clcd_pkg::cfg_t                 cfg
);
  import clcd_pkg::*;

  logic [NUM_REGS-1:0][REG_W-1:0] len;
  logic [NUM_REGS-1:0]            zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= REG_RESET;
      zero <= '0;
    end else if (cfg_we) begin
      len[cfg_index]  <= cfg_data;
      zero[cfg_index] <= (cfg_data == '0);
    end
  end

  assign cfg.len  = len;
  assign cfg.zero = zero;

endmodule

/* hdl/clcd_phase_find.sv */
// ---------------------------------------------------------------------------
// clcd_phase_find: next non-empty position
// Priority search for the first position at or after a start point whose
// phase takes at least one tick; end positions always qualify.
// ---------------------------------------------------------------------------
module clcd_phase_find (
  input  logic [clcd_pkg::POS_W-1:0]   from,
  input  logic [clcd_pkg::NUM_POS-1:0] mask,
  output logic [clcd_pkg::POS_W-1:0]   first
);
  import clcd_pkg::*;

  always_comb begin
    first = POS_W'(NUM_POS - 1);
    for (int i = NUM_POS - 1; i >= 0; i--) begin
      if ((POS_W'(i) >= from) && mask[i]) begin
        first = POS_W'(i);
      end
    end
  end

endmodule

/* hdl/clcd_seq_core.sv */
// ---------------------------------------------------------------------------
// clcd_seq_core: LCD sequencer
// One tick per transfer: starts a sequence on an idle tick, drives the pin
// levels, counts the tick into the current phase and steps past empty ones.
// ---------------------------------------------------------------------------
module clcd_seq_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  clcd_pkg::req_t req,
  input  clcd_pkg::cfg_t cfg,
  output clcd_pkg::res_t res
);
  import clcd_pkg::*;

  logic             busy;
  logic [POS_W-1:0] pos;
  logic [REG_W-1:0] counter;
  logic [7:0]       current_byte;
  logic             clear_flag;
  logic             rs_level;
  logic             enable_level;
  logic [3:0]       nibble_level;

  logic             busy_next;
  logic [POS_W-1:0] pos_next;
  logic [REG_W-1:0] counter_next;
  logic             rs_level_next;
  logic             enable_level_next;
  logic [3:0]       nibble_level_next;

  logic               start;
  logic [6:0]         cursor_addr;
  logic [7:0]         byte_start;
  logic [7:0]         byte_cur;
  logic               clear_cur;
  logic               rs_base;
  logic [POS_W-1:0]   from_start;
  logic [NUM_POS-1:0] mask;
  logic [POS_W-1:0]   found_start;
  logic [POS_W-1:0]   found_after;
  logic [POS_W-1:0]   land;
  pos_info_t          info_land;
  pos_info_t          info_after;
  pos_info_t          info_mask;
  logic               busy_cur;
  logic               rs_cur;
  logic               enable_cur;
  logic [3:0]         nibble_cur;
  logic [REG_W-1:0]   count_base;
  logic [REG_W:0]     count_inc;
  logic [REG_W-1:0]   phase_len;
  logic               phase_done;

  assign start = !busy && req.request_valid && (req.operation <= OP_CLEAR);
  assign cursor_addr = {req.row, 6'b0} + {1'b0, req.col};

  always_comb begin
    case (op_t'(req.operation))
      OP_CMD, OP_DATA: byte_start = req.byte_value;
      OP_CURSOR:       byte_start = {1'b1, cursor_addr};
      OP_CLEAR:        byte_start = CMD_CLEAR;
      default:         byte_start = current_byte;
    endcase
  end

  assign byte_cur   = start ? byte_start : current_byte;
  assign clear_cur  = start ? (req.operation == OP_CLEAR) : clear_flag;
  // init leaves rs where it was until the first nibble
  assign rs_base    = (start && (req.operation != OP_INIT)) ? (req.operation == OP_DATA)
                                                            : rs_level;
  assign from_start = (req.operation == OP_INIT) ? POS_W'(P_POWERUP) : POS_W'(P_BYTE);

  // a position qualifies when its phase lasts at least one tick
  always_comb begin
    for (int i = 0; i < NUM_POS; i++) begin
      info_mask = pos_info(POS_W'(i));
      if (info_mask.sel == SEL_END) begin
        mask[i] = 1'b1;
      end else if (info_mask.sel == SEL_CLEAR_EXTRA) begin
        mask[i] = clear_cur && !cfg.zero[info_mask.sel[REG_IDX_W-1:0]];
      end else begin
        mask[i] = !cfg.zero[info_mask.sel[REG_IDX_W-1:0]];
      end
    end
  end

  clcd_phase_find u_find_start (
    .from  (from_start),
    .mask  (mask),
    .first (found_start)
  );

  assign land      = start ? found_start : pos;
  assign info_land = pos_info(land);
  assign busy_cur  = start ? (info_land.sel != SEL_END) : busy;

  assign rs_cur     = start ? (!info_land.rs_clear && rs_base) : rs_level;
  assign enable_cur = start ? (info_land.sel == SEL_ENABLE_HIGH) : enable_level;
  assign nibble_cur = start ? nib_level(info_land, byte_cur, nibble_level) : nibble_level;

  // tick counts toward the phase shown on it
  assign count_base = start ? '0 : counter;
  assign count_inc  = {1'b0, count_base} + (REG_W+1)'(1);
  assign phase_len  = cfg.len[info_land.sel[REG_IDX_W-1:0]];
  assign phase_done = (count_inc >= {1'b0, phase_len});

  clcd_phase_find u_find_after (
    .from  (land + POS_W'(1)),
    .mask  (mask),
    .first (found_after)
  );

  assign info_after = pos_info(found_after);

  always_comb begin
    pos_next          = pos;
    busy_next         = busy;
    counter_next      = counter;
    rs_level_next     = rs_level;
    enable_level_next = enable_level;
    nibble_level_next = nibble_level;
    if (take) begin
      pos_next          = land;
      busy_next         = busy_cur;
      counter_next      = '0;
      rs_level_next     = rs_cur;
      enable_level_next = enable_cur;
      nibble_level_next = nibble_cur;
      if (busy_cur) begin
        if (phase_done) begin
          pos_next          = found_after;
          busy_next         = (info_after.sel != SEL_END);
          rs_level_next     = !info_after.rs_clear && rs_cur;
          enable_level_next = (info_after.sel == SEL_ENABLE_HIGH);
          nibble_level_next = nib_level(info_after, byte_cur, nibble_cur);
        end else begin
          counter_next = count_inc[REG_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pos          <= POS_W'(P_BYTE_END);
      counter      <= '0;
      current_byte <= '0;
      clear_flag   <= 1'b0;
      rs_level     <= 1'b0;
      enable_level <= 1'b0;
      nibble_level <= '0;
    end else begin
      busy         <= busy_next;
      pos          <= pos_next;
      counter      <= counter_next;
      rs_level     <= rs_level_next;
      enable_level <= enable_level_next;
      nibble_level <= nibble_level_next;
      if (take && start) begin
        current_byte <= byte_cur;
        clear_flag   <= clear_cur;
      end
    end
  end

  assign res.rs_pin          = rs_cur;
  assign res.enable_pin      = enable_cur;
  assign res.data_nibble     = nibble_cur;
  assign res.busy_res        = busy_cur;
  assign res.request_dropped = busy && req.request_valid;

  // busy exactly when parked on a timed position
  a_busy_pos : assert property (@(posedge clk) disable iff (rst)
    busy == (pos_info(pos).sel != SEL_END))
    else $error("busy flag disagrees with sequence position");

  a_enable_busy : assert property (@(posedge clk) disable iff (rst)
    enable_level |-> busy)
    else $error("enable left high outside a sequence");

  a_hold_idle : assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(pos) && $stable(counter) && $stable(busy))
    else $error("sequencer moved without a tick");

endmodule

/* hdl/char_lcd_4bit_interface.sv */
// ---------------------------------------------------------------------------
// char_lcd_4bit_interface: 4-bit character LCD driver
// Every transfer on the item channel is one microsecond tick, optionally
// carrying a request (init, command, data, set cursor, clear). Every tick
// yields one result transfer with the RS, EN and D7..D4 levels for that
// tick, a busy flag and a dropped flag for a request made while busy.
// An item goes through the input register, then through the sequencer into
// the result register. Throughput is one tick per cycle while results are
// taken; the sequencer state updates once per tick, so items keep flowing
// while a sequence runs.
// When the result consumer stalls, the result register holds and the input
// register fills, then item_ready drops until the result is taken.
// Reset restores the default tick lengths, leaves the sequencer idle with
// its pin levels low (result register not reset). Timing registers may be
// written at any cycle; they must only be changed while no sequence is running.
// ---------------------------------------------------------------------------
module char_lcd_4bit_interface (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic                           request_valid,
  input  logic [2:0]                     operation,
  input  logic [7:0]                     byte_value,
  input  logic                           row,
  input  logic [5:0]                     col,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic                           rs_pin,
  output logic                           enable_pin,
  output logic [3:0]                     data_nibble,
  output logic                           busy_res,
  output logic                           request_dropped,
  input  logic                           cfg_we,
  input  logic [clcd_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [clcd_pkg::REG_W-1:0]     cfg_data
);
  import clcd_pkg::*;

  cfg_t cfg;
  logic s1_valid;
  req_t s1_req;
  res_t res_comb;
  res_t res_q;
  logic advance;
  logic take;

  assign advance    = !res_valid || res_ready;
  assign take       = s1_valid && advance;
  assign item_ready = !s1_valid || advance;

  clcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_req.request_valid <= request_valid;
      s1_req.operation     <= operation;
      s1_req.byte_value    <= byte_value;
      s1_req.row           <= row;
      s1_req.col           <= col;
    end
  end

  clcd_seq_core u_core (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .req  (s1_req),
    .cfg  (cfg),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res_comb;
    end
  end

  assign rs_pin          = res_q.rs_pin;
  assign enable_pin      = res_q.enable_pin;
  assign data_nibble     = res_q.data_nibble;
  assign busy_res        = res_q.busy_res;
  assign request_dropped = res_q.request_dropped;

endmodule
